@@ src/va_pkg.sv @@
package va_pkg;

    // pool size and fixed field widths
    localparam int VA_VOICES  = 16;
    localparam int VA_STAMP_W = 32;
    localparam int VA_ID_W    = 4;

    // command codes
    localparam logic VA_CMD_TRIGGER = 1'b0;
    localparam logic VA_CMD_RELEASE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_STEAL,
        S_DRAIN,
        S_DONE
    } t_state;

    // control for one beat into the age compare unit
    typedef struct packed {
        logic vld;
        logic first;
    } t_age_ctl;

endpackage

@@ src/va_stamp_mem.sv @@
module va_stamp_mem import va_pkg::*; #(
    parameter int DEPTH = VA_VOICES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [VA_STAMP_W-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [VA_STAMP_W-1:0] o_rd_data
);

    logic [VA_STAMP_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      r_ok;
    logic [VA_STAMP_W-1:0] r_rd_data;
    logic                  r_rd_ok;

    // per-entry written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_wr_en) begin
            r_ok[i_wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_ok   <= r_ok[i_rd_addr];
        end
    end

    // an entry never written reads as zero
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

@@ src/va_age_unit.sv @@
module va_age_unit import va_pkg::*; #(
    parameter int VOICES = VA_VOICES
) (
    input  logic                      i_clk,
    input  t_age_ctl                  i_ctl,
    input  logic [$clog2(VOICES)-1:0] i_idx,
    input  logic [VA_STAMP_W-1:0]     i_counter,
    input  logic [VA_STAMP_W-1:0]     i_stamp,
    output logic [$clog2(VOICES)-1:0] o_best_idx
);

    localparam int IW = $clog2(VOICES);

    logic [VA_STAMP_W-1:0] w_age;
    logic                  w_take;
    logic [VA_STAMP_W-1:0] r_best_age;
    logic [IW-1:0]         r_best_idx;

    // wrapping age and strict compare, so ties keep the lower index
    always_comb begin
        w_age  = i_counter - i_stamp;
        w_take = i_ctl.vld && (i_ctl.first || (w_age > r_best_age));
    end

    // running oldest voice
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_age <= w_age;
            r_best_idx <= i_idx;
        end
    end

    assign o_best_idx = r_best_idx;

endmodule

@@ src/voice_allocator_oldest_steal.sv @@
// Release beat: clears the busy flag of the given voice in S_IDLE, no result.
// Trigger beat: S_FIND scans busy flags from the pointer, one voice per cycle, and goes to
// S_DONE at the first free voice; if none is free, S_STEAL reads every stamp, one entry per
// cycle, then S_DRAIN and S_DONE steal the oldest voice, written when the output is free.
// A new beat is taken once the previous trigger has been written to the result register.
// Synchronous active-low reset clears busy flags, pointer, counter and stamp flags at once.
module voice_allocator_oldest_steal import va_pkg::*; #(
    parameter int VOICES = VA_VOICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic [VA_ID_W-1:0] i_voice_id,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VA_ID_W-1:0] o_chosen_voice,
    output logic               o_was_stolen
);

    localparam int IW = $clog2(VOICES);
    localparam int EW = (IW > VA_ID_W) ? IW : VA_ID_W;

    t_state                r_state, n_state;
    logic [VOICES-1:0]     r_busy, n_busy;
    logic [IW-1:0]         r_ptr, n_ptr;
    logic [VA_STAMP_W-1:0] r_count, n_count;
    logic [IW-1:0]         r_scan, n_scan;
    logic [IW-1:0]         r_choice, n_choice;
    logic                  r_stolen, n_stolen;
    t_age_ctl              r_rd_ctl, n_rd_ctl;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_o_valid, n_o_valid;
    logic [VA_ID_W-1:0]    r_o_voice, n_o_voice;
    logic                  r_o_stolen, n_o_stolen;

    logic [IW:0]           w_sum;
    logic [IW:0]           w_sum_wrap;
    logic [IW-1:0]         w_v;
    logic [EW-1:0]         w_id_ext;
    logic                  w_id_ok;
    logic [IW-1:0]         w_id;
    logic [IW-1:0]         w_best_idx;
    logic [IW-1:0]         w_pick;
    logic [EW-1:0]         w_pick_ext;
    logic                  w_rd_en;
    logic                  w_wr_en;
    logic [VA_STAMP_W-1:0] w_stamp;

    // stamp store
    va_stamp_mem #(
        .DEPTH (VOICES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_pick),
        .i_wr_data (r_count),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_scan),
        .o_rd_data (w_stamp)
    );

    // shared age subtract and compare
    va_age_unit #(
        .VOICES (VOICES)
    ) u_age (
        .i_clk      (i_clk),
        .i_ctl      (r_rd_ctl),
        .i_idx      (r_rd_idx),
        .i_counter  (r_count),
        .i_stamp    (w_stamp),
        .o_best_idx (w_best_idx)
    );

    // round-robin candidate and release index decode
    always_comb begin
        w_sum      = {1'b0, r_ptr} + {1'b0, r_scan};
        w_sum_wrap = w_sum - (IW+1)'(VOICES);
        w_v        = (w_sum >= (IW+1)'(VOICES)) ? w_sum_wrap[IW-1:0] : w_sum[IW-1:0];
        w_id_ext   = EW'(i_voice_id);
        w_id_ok    = ({1'b0, w_id_ext} < (EW+1)'(VOICES));
        w_id       = w_id_ext[IW-1:0];
        w_pick     = r_stolen ? w_best_idx : r_choice;
        w_pick_ext = EW'(w_pick);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_ptr      = r_ptr;
        n_count    = r_count;
        n_scan     = r_scan;
        n_choice   = r_choice;
        n_stolen   = r_stolen;
        n_rd_ctl   = '0;
        n_rd_idx   = r_rd_idx;
        n_o_valid  = r_o_valid && i_stall;
        n_o_voice  = r_o_voice;
        n_o_stolen = r_o_stolen;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == VA_CMD_RELEASE) begin
                        if (w_id_ok) begin
                            n_busy[w_id] = 1'b0;
                        end
                    end else begin
                        n_scan  = '0;
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (!r_busy[w_v]) begin
                    n_choice = w_v;
                    n_stolen = 1'b0;
                    n_state  = S_DONE;
                end else if (r_scan == IW'(VOICES - 1)) begin
                    n_scan  = '0;
                    n_state = S_STEAL;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_STEAL: begin
                w_rd_en        = 1'b1;
                n_rd_ctl.vld   = 1'b1;
                n_rd_ctl.first = (r_scan == '0);
                n_rd_idx       = r_scan;
                if (r_scan == IW'(VOICES - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DRAIN: begin
                n_stolen = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid      = 1'b1;
                    n_o_voice      = w_pick_ext[VA_ID_W-1:0];
                    n_o_stolen     = r_stolen;
                    n_busy[w_pick] = 1'b1;
                    w_wr_en        = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_ptr          = (w_pick == IW'(VOICES - 1)) ? '0 : w_pick + 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= '0;
            r_ptr     <= '0;
            r_count   <= '0;
            r_rd_ctl  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_ptr     <= n_ptr;
            r_count   <= n_count;
            r_rd_ctl  <= n_rd_ctl;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_choice   <= n_choice;
        r_stolen   <= n_stolen;
        r_rd_idx   <= n_rd_idx;
        r_o_voice  <= n_o_voice;
        r_o_stolen <= n_o_stolen;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_chosen_voice = r_o_voice;
    assign o_was_stolen   = r_o_stolen;

endmodule
